FILE: hw/rtl/gcs_pkg.sv
// Shared types, codes and defaults for the Golomb-coded set matcher.
package gcs_pkg;

    localparam int GCS_COUNT_BITS  = 32;
    localparam int GCS_QUEUE_DEPTH = 4;
    localparam int GCS_RES_DEPTH   = 2;

    localparam logic [5:0] GCS_RICE_RESET = 6'd19;

    // configuration register indexes
    localparam logic [1:0] REG_RICE_PARAM   = 2'd0;
    localparam logic [1:0] REG_MEMBER_LIMIT = 2'd1;
    localparam logic [1:0] REG_TARGET_RANGE = 2'd2;

    // verdict causes
    localparam logic [1:0] CAUSE_EQUAL     = 2'd0;
    localparam logic [1:0] CAUSE_PASSED    = 2'd1;
    localparam logic [1:0] CAUSE_EXHAUSTED = 2'd2;
    localparam logic [1:0] CAUSE_STREAM_END = 2'd3;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       first_byte;
        logic       last_byte;
    } gcs_in_t;

    typedef struct packed {
        logic        found;
        logic [1:0]  verdict_cause;
        logic [31:0] elements_decoded;
    } gcs_out_t;

    typedef struct packed {
        logic [5:0]  rice_param;
        logic [31:0] member_limit;
        logic [63:0] target_range;
    } gcs_cfg_t;

endpackage

FILE: hw/rtl/gcs_queue.sv
// Small first-in first-out queue built from registers.
module gcs_queue #(
    parameter int DEPTH = 4,
    parameter int W     = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/gcs_front.sv
// Input stage: registers each incoming byte transaction and forwards it to the work queue.
module gcs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gcs_pkg::gcs_in_t  item,
    output logic              full,
    input  logic              wq_full,
    output logic              wq_push,
    output gcs_pkg::gcs_in_t  wq_item
);

    import gcs_pkg::*;

    logic    vld_reg, vld_next;
    gcs_in_t item_reg;
    logic    accept;

    // holding register drains whenever the queue has room
    assign full    = vld_reg && wq_full;
    assign accept  = push && !full;
    assign wq_push = vld_reg && !wq_full;
    assign wq_item = item_reg;

    assign vld_next = accept || (vld_reg && wq_full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

endmodule

FILE: hw/rtl/gcs_back.sv
// Decoder: walks the bits of each byte, rebuilds set values and issues the verdict.
module gcs_back #(
    parameter int COUNT_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gcs_pkg::gcs_cfg_t cfg,
    input  logic              item_vld,
    input  gcs_pkg::gcs_in_t  item,
    output logic              item_take,
    input  logic              res_ready,
    output logic              res_push,
    output gcs_pkg::gcs_out_t res
);

    import gcs_pkg::*;

    logic [63:0]           q_reg, q_next;
    logic                  inr_reg, inr_next;
    logic [5:0]            rl_reg, rl_next;
    logic [63:0]           ra_reg, ra_next;
    logic [63:0]           prev_reg, prev_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  vg_reg, vg_next;
    logic [2:0]            pos_reg, pos_next;

    always_comb
    begin
        logic                  clr;
        logic [63:0]           q_e;
        logic                  inr_e;
        logic [5:0]            rl_e;
        logic [63:0]           ra_e;
        logic [63:0]           prev_e;
        logic [COUNT_BITS-1:0] cnt_e;
        logic                  vg_e;
        logic                  exh;
        logic                  inr_w;
        logic [5:0]            rl_w;
        logic [63:0]           ra_w;
        logic [3:0]            qi;
        logic                  stop;
        logic [3:0]            used;
        logic                  b;
        logic [63:0]           value;
        logic [COUNT_BITS-1:0] cnt_inc;
        logic [63:0]           cnt_e_w;
        logic [63:0]           cnt_inc_w;

        clr    = item.first_byte && (pos_reg == 3'd0);
        q_e    = clr ? '0 : q_reg;
        inr_e  = clr ? 1'b0 : inr_reg;
        rl_e   = clr ? '0 : rl_reg;
        ra_e   = clr ? '0 : ra_reg;
        prev_e = clr ? '0 : prev_reg;
        cnt_e  = clr ? '0 : cnt_reg;
        vg_e   = clr ? 1'b0 : vg_reg;

        cnt_inc   = cnt_e + 1'b1;
        cnt_e_w   = 64'(cnt_e);
        cnt_inc_w = 64'(cnt_inc);
        exh       = cnt_e_w >= 64'(cfg.member_limit);

        // bit walk from the current position up to the first completed element
        inr_w = inr_e;
        rl_w  = rl_e;
        ra_w  = ra_e;
        qi    = '0;
        stop  = 1'b0;
        used  = 4'({1'b0, pos_reg});
        b     = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if ((4'(i) >= {1'b0, pos_reg}) && !stop)
            begin
                b    = item.stream_byte[7-i];
                used = 4'(i + 1);
                if (!inr_w)
                begin
                    if (b)
                    begin
                        qi = qi + 1'b1;
                    end
                    else if (cfg.rice_param == 6'd0)
                    begin
                        ra_w = '0;
                        stop = 1'b1;
                    end
                    else
                    begin
                        inr_w = 1'b1;
                        rl_w  = cfg.rice_param;
                        ra_w  = '0;
                    end
                end
                else
                begin
                    ra_w = {ra_w[62:0], b};
                    rl_w = rl_w - 6'd1;
                    if (rl_w == 6'd0)
                    begin
                        stop = 1'b1;
                    end
                end
            end
        end

        // quotient shifted with the current parameter, all modulo 2^64
        value = prev_e + (q_e << cfg.rice_param) + (64'(qi) << cfg.rice_param) + ra_w;

        q_next    = q_reg;
        inr_next  = inr_reg;
        rl_next   = rl_reg;
        ra_next   = ra_reg;
        prev_next = prev_reg;
        cnt_next  = cnt_reg;
        vg_next   = vg_reg;
        pos_next  = pos_reg;
        item_take = 1'b0;
        res_push  = 1'b0;
        res       = '0;

        if (item_vld && res_ready)
        begin
            q_next    = q_e;
            inr_next  = inr_e;
            rl_next   = rl_e;
            ra_next   = ra_e;
            prev_next = prev_e;
            cnt_next  = cnt_e;
            vg_next   = vg_e;
            pos_next  = 3'd0;
            item_take = 1'b1;

            if (vg_e)
            begin
                // query already decided: byte dropped
            end
            else if (exh)
            begin
                vg_next                = 1'b1;
                res_push               = 1'b1;
                res.verdict_cause      = CAUSE_EXHAUSTED;
                res.elements_decoded   = cnt_e_w[31:0];
            end
            else if (stop)
            begin
                cnt_next = cnt_inc;
                q_next   = '0;
                inr_next = 1'b0;
                rl_next  = '0;
                ra_next  = '0;
                if (value == cfg.target_range)
                begin
                    vg_next              = 1'b1;
                    res_push             = 1'b1;
                    res.found            = 1'b1;
                    res.verdict_cause    = CAUSE_EQUAL;
                    res.elements_decoded = cnt_inc_w[31:0];
                end
                else if (value > cfg.target_range)
                begin
                    vg_next              = 1'b1;
                    res_push             = 1'b1;
                    res.verdict_cause    = CAUSE_PASSED;
                    res.elements_decoded = cnt_inc_w[31:0];
                end
                else
                begin
                    prev_next = value;
                    if (used == 4'd8)
                    begin
                        if (cnt_inc_w >= 64'(cfg.member_limit))
                        begin
                            vg_next              = 1'b1;
                            res_push             = 1'b1;
                            res.verdict_cause    = CAUSE_EXHAUSTED;
                            res.elements_decoded = cnt_inc_w[31:0];
                        end
                        else if (item.last_byte)
                        begin
                            vg_next              = 1'b1;
                            res_push             = 1'b1;
                            res.verdict_cause    = CAUSE_STREAM_END;
                            res.elements_decoded = cnt_inc_w[31:0];
                        end
                    end
                    else
                    begin
                        // more bits of this byte to walk: the byte stays at the queue head
                        item_take = 1'b0;
                        pos_next  = used[2:0];
                    end
                end
            end
            else
            begin
                q_next   = q_e + 64'(qi);
                inr_next = inr_w;
                rl_next  = rl_w;
                ra_next  = ra_w;
                if (item.last_byte)
                begin
                    vg_next              = 1'b1;
                    res_push             = 1'b1;
                    res.verdict_cause    = CAUSE_STREAM_END;
                    res.elements_decoded = cnt_e_w[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            inr_reg  <= 1'b0;
            rl_reg   <= '0;
            ra_reg   <= '0;
            prev_reg <= '0;
            cnt_reg  <= '0;
            vg_reg   <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            q_reg    <= q_next;
            inr_reg  <= inr_next;
            rl_reg   <= rl_next;
            ra_reg   <= ra_next;
            prev_reg <= prev_next;
            cnt_reg  <= cnt_next;
            vg_reg   <= vg_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

FILE: hw/rtl/gcs_single_member_match.sv
// Top level of the Golomb-Rice coded set single member matcher.
//
//  channel   direction  handshake            payload
//  input     in         push / full          in_item  : stream_byte, first_byte, last_byte
//  result    out        empty / pop          out_item : found, verdict_cause, elements_decoded
//  config    in         cfg_wr_en            cfg_index, cfg_data (64 bits)
//
// One byte transaction is decoded per cycle while the result queue has room;
// a byte in which an element completes before its last bit stays at the
// head of the work queue and is walked again for each such element. The
// limit is the single value adder and target compare in the decoder.
// Reset clears all query state and loads the register defaults; no sweep.
// Input is taken unless holding register and work queue are both full, so a
// stalled result side fills result queue, work queue, then holding register
// before full rises. A byte passes the holding register and the work queue
// to the decoder; its verdict is registered in the result queue for output.
module gcs_single_member_match #(
    parameter int COUNT_BITS  = gcs_pkg::GCS_COUNT_BITS,
    parameter int QUEUE_DEPTH = gcs_pkg::GCS_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gcs_pkg::gcs_in_t  in_item,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output gcs_pkg::gcs_out_t out_item,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data
);

    import gcs_pkg::*;

    localparam int IN_W  = $bits(gcs_in_t);
    localparam int OUT_W = $bits(gcs_out_t);

    // configuration registers, live as soon as written
    logic [5:0]  rice_param_reg;
    logic [31:0] member_limit_reg;
    logic [63:0] target_range_reg;
    gcs_cfg_t    cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rice_param_reg   <= GCS_RICE_RESET;
            member_limit_reg <= '0;
            target_range_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_RICE_PARAM:   rice_param_reg   <= cfg_data[5:0];
                REG_MEMBER_LIMIT: member_limit_reg <= cfg_data[31:0];
                REG_TARGET_RANGE: target_range_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign cfg.rice_param   = rice_param_reg;
    assign cfg.member_limit = member_limit_reg;
    assign cfg.target_range = target_range_reg;

    // front: input holding register
    logic    wq_full;
    logic    wq_push;
    gcs_in_t wq_wr_item;

    gcs_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (in_item),
        .full    (full),
        .wq_full (wq_full),
        .wq_push (wq_push),
        .wq_item (wq_wr_item)
    );

    // work queue decouples intake from decoding
    logic            wq_empty;
    logic            wq_take;
    logic [IN_W-1:0] wq_rd_data;
    gcs_in_t         wq_head;

    gcs_queue #(
        .DEPTH (QUEUE_DEPTH),
        .W     (IN_W)
    ) u_work_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wq_push),
        .wr_data (IN_W'(wq_wr_item)),
        .full    (wq_full),
        .rd_en   (wq_take),
        .rd_data (wq_rd_data),
        .empty   (wq_empty)
    );

    assign wq_head = gcs_in_t'(wq_rd_data);

    // back: bit walk and value compare
    logic     rq_full;
    logic     rq_push;
    gcs_out_t verdict;

    gcs_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .item_vld  (!wq_empty),
        .item      (wq_head),
        .item_take (wq_take),
        .res_ready (!rq_full),
        .res_push  (rq_push),
        .res       (verdict)
    );

    // result queue: verdicts wait here for the consumer
    logic [OUT_W-1:0] rq_rd_data;

    gcs_queue #(
        .DEPTH (GCS_RES_DEPTH),
        .W     (OUT_W)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rq_push),
        .wr_data (OUT_W'(verdict)),
        .full    (rq_full),
        .rd_en   (pop),
        .rd_data (rq_rd_data),
        .empty   (empty)
    );

    assign out_item = gcs_out_t'(rq_rd_data);

endmodule

FILE: sim/gcs_single_member_match_tb.sv
// Self-checking testbench for the Golomb-Rice coded set single member matcher.
module gcs_single_member_match_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gcs_pkg::*;

    // Idle cycles after the last verdict before touching the registers: room for
    // up to five waiting bytes (holding register and work queue), each walked
    // once per element with rice_param zero, plus the pipeline itself.
    localparam int SETTLE_CYCLES  = 64;
    // Cycles without any accepted transaction before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 620;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    gcs_in_t     in_item = '0;
    logic        full;
    logic        empty;
    logic        pop = 1'b0;
    gcs_out_t    out_item;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_RICE_PARAM;
    logic [63:0] cfg_data = '0;

    gcs_single_member_match u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder model: register copies and query state
    // ------------------------------------------------------------------
    logic [5:0]                cur_rice;
    logic [31:0]               cur_size;
    logic [63:0]               cur_target;
    logic [63:0]               q_cnt;
    logic                      in_rem;
    logic [5:0]                rem_left;
    logic [63:0]               rem_acc;
    logic [63:0]               prev_val;
    logic [GCS_COUNT_BITS-1:0] elem_cnt;
    logic                      verdict_done;

    gcs_out_t pending_verdicts[$];

    // stream under construction and the running values it codes
    gcs_in_t     stream_bytes[$];
    logic [63:0] coded_values[$];

    int fail_count = 0;
    int sent_items = 0;
    int live_items = 0;
    int checked    = 0;
    int found_seen = 0;
    int cause_seen[4];
    int burst_left = 0;
    int pop_mode   = 0;
    int pop_left   = 0;
    int idle_cycles = 0;
    gcs_out_t want;

    function automatic void clear_query();
        q_cnt        = '0;
        in_rem       = 1'b0;
        rem_left     = '0;
        rem_acc      = '0;
        prev_val     = '0;
        elem_cnt     = '0;
        verdict_done = 1'b0;
    endfunction

    function automatic bit close_query(output gcs_out_t res, input logic is_found,
                                       input logic [1:0] cause);
        verdict_done         = 1'b1;
        res.found            = is_found;
        res.verdict_cause    = cause;
        res.elements_decoded = 32'(elem_cnt);
        return 1'b1;
    endfunction

    // Completes one element; the shift uses rice_param as it stands now.
    function automatic bit finish_element(output gcs_out_t res);
        logic [63:0] value;
        value    = prev_val + ((q_cnt << cur_rice) + rem_acc);
        elem_cnt = elem_cnt + 1'b1;
        q_cnt    = '0;
        in_rem   = 1'b0;
        rem_left = '0;
        rem_acc  = '0;
        if (value == cur_target)
            return close_query(res, 1'b1, CAUSE_EQUAL);
        if (value > cur_target)
            return close_query(res, 1'b0, CAUSE_PASSED);
        prev_val = value;
        return 1'b0;
    endfunction

    // One byte, MSB first. Returns 1 when the byte gives a verdict.
    function automatic bit decode_byte(input gcs_in_t it, output gcs_out_t res,
                                       output bit skipped);
        logic b;
        res     = '0;
        skipped = 1'b0;
        if (it.first_byte)
            clear_query();
        if (verdict_done)
        begin
            skipped = 1'b1;
            return 1'b0;
        end
        for (int pos = 7; pos >= 0; pos--)
        begin
            b = it.stream_byte[pos];
            // exhaustion is checked ahead of every bit
            if (32'(elem_cnt) >= cur_size)
                return close_query(res, 1'b0, CAUSE_EXHAUSTED);
            if (!in_rem)
            begin
                if (b)
                begin
                    q_cnt = q_cnt + 1'b1;
                end
                else if (cur_rice == 6'd0)
                begin
                    // no remainder: the element ends at the stop bit
                    rem_acc = '0;
                    if (finish_element(res))
                        return 1'b1;
                end
                else
                begin
                    in_rem   = 1'b1;
                    rem_left = cur_rice;
                    rem_acc  = '0;
                end
            end
            else
            begin
                rem_acc  = {rem_acc[62:0], b};
                rem_left = rem_left - 1'b1;
                if (rem_left == 6'd0)
                begin
                    if (finish_element(res))
                        return 1'b1;
                end
            end
        end
        if (32'(elem_cnt) >= cur_size)
            return close_query(res, 1'b0, CAUSE_EXHAUSTED);
        // stream end also applies in the middle of a code
        if (it.last_byte)
            return close_query(res, 1'b0, CAUSE_STREAM_END);
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Every task starts and ends just after a falling edge.
    // ------------------------------------------------------------------
    task automatic pause(input int cycles);
        push <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Shared by every test: one byte transaction, with bursts and gaps.
    task automatic send_byte(input gcs_in_t it);
        gcs_out_t res;
        bit       skipped;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 5) != 0)
                pause($urandom_range(1, 10));
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        in_item <= it;
        push    <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (decode_byte(it, res, skipped))
            pending_verdicts.push_back(res);
        if (!skipped)
            live_items++;
        sent_items++;
        @(negedge clk);
    endtask

    // Sender holds off until every predicted verdict has been taken.
    task automatic hold_until_drained();
        push <= 1'b0;
        @(negedge clk);
        while (pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    // A byte with no verdict may still be in flight: give it time to retire.
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_RICE_PARAM:   cur_rice   = val[5:0];
            REG_MEMBER_LIMIT: cur_size   = val[31:0];
            REG_TARGET_RANGE: cur_target = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Only called with the block idle.
    task automatic configure(input logic [5:0] rice, input logic [31:0] size,
                             input logic [63:0] target);
        write_reg(REG_RICE_PARAM, {58'd0, rice});
        write_reg(REG_MEMBER_LIMIT, {32'd0, size});
        write_reg(REG_TARGET_RANGE, target);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Codes n elements with p remainder bits into stream_bytes; the spare
    // bits of the final byte are random.
    task automatic build_set(input int n, input int p, input int qmin, input int qmax);
        bit          bits[$];
        logic [63:0] acc;
        logic [63:0] rem;
        int          q;
        gcs_in_t     it;
        stream_bytes.delete();
        coded_values.delete();
        acc = '0;
        for (int e = 0; e < n; e++)
        begin
            q   = $urandom_range(qmax, qmin);
            rem = {$urandom, $urandom};
            rem = rem & ((64'd1 << p) - 64'd1);
            repeat (q) bits.push_back(1'b1);
            bits.push_back(1'b0);
            for (int k = p - 1; k >= 0; k--)
                bits.push_back(rem[k]);
            acc = acc + (64'(q) << p) + rem;
            coded_values.push_back(acc);
        end
        while (bits.size() != 0)
        begin
            it             = '0;
            it.stream_byte = 8'($urandom);
            for (int k = 7; k >= 0; k--)
                if (bits.size() != 0)
                    it.stream_byte[k] = bits.pop_front();
            stream_bytes.push_back(it);
        end
        stream_bytes[0].first_byte = 1'b1;
        stream_bytes[stream_bytes.size() - 1].last_byte = 1'b1;
    endtask

    // Optionally stops halfway so the matcher drains in the middle of a query.
    task automatic run_stream(input bit hold_midway);
        for (int i = 0; i < stream_bytes.size(); i++)
        begin
            if (hold_midway && i == stream_bytes.size() / 2)
                hold_until_drained();
            send_byte(stream_bytes[i]);
        end
    endtask

    function automatic gcs_in_t mk_byte(input logic [7:0] b, input logic f, input logic l);
        gcs_in_t it;
        it.stream_byte = b;
        it.first_byte  = f;
        it.last_byte   = l;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the member limit is zero, so the first byte is exhausted unread.
    task automatic test_reset_defaults();
        send_byte(mk_byte(8'hA5, 1'b1, 1'b0));
        settle();
    endtask

    task automatic test_empty_set();
        configure(6'd5, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(mk_byte(8'h00, 1'b1, 1'b1));
        settle();
    endtask

    // No remainder bits: each stop bit ends an element; all-zero and
    // all-one bytes, and a mixed byte.
    task automatic test_rice_zero();
        configure(6'd0, 32'd100, 64'd6);
        send_byte(mk_byte(8'h00, 1'b1, 1'b0));
        send_byte(mk_byte(8'hFF, 1'b0, 1'b1));
        settle();
        configure(6'd0, 32'd100, 64'd2);
        send_byte(mk_byte(8'b1010_0000, 1'b1, 1'b1));
        settle();
    endtask

    // Equal, passed, exhausted after the member limit, and stream ended.
    task automatic test_verdict_causes();
        build_set(3, 3, 0, 1);
        configure(6'd3, 32'd3, coded_values[1]);
        run_stream(1'b0);
        settle();
        build_set(3, 3, 1, 1);
        configure(6'd3, 32'd3, coded_values[0] + 64'd1);
        run_stream(1'b0);
        settle();
        build_set(3, 3, 0, 1);
        configure(6'd3, 32'd2, 64'hFFFF_FFFF_FFFF_FFFF);
        run_stream(1'b0);
        settle();
        build_set(3, 3, 0, 1);
        configure(6'd3, 32'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        run_stream(1'b0);
        settle();
    endtask

    // Bytes after a verdict are dropped until first_byte opens a new query.
    task automatic test_after_verdict();
        configure(6'd4, 32'd10, 64'd0);
        send_byte(mk_byte(8'h00, 1'b1, 1'b0));
        send_byte(mk_byte(8'h00, 1'b0, 1'b0));
        send_byte(mk_byte(8'hFF, 1'b0, 1'b1));
        send_byte(mk_byte(8'h80, 1'b1, 1'b1));
        settle();
    endtask

    // Widest remainder: a quotient of two shifted by 63 wraps to zero.
    task automatic test_wide_rice();
        build_set(1, 63, 2, 2);
        configure(6'd63, 32'd2, coded_values[0]);
        run_stream(1'b0);
        settle();
    endtask

    // Mostly well-formed sets with random content and registers, the rest
    // truncated, unterminated or plain noise.
    task automatic test_random_sets();
        int          start;
        int          set_no;
        int          p;
        int          n;
        int          qmax;
        int          shape;
        int          cut;
        logic [31:0] size;
        logic [63:0] target;
        gcs_in_t     it;
        start  = sent_items;
        set_no = 0;
        while (sent_items - start < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       p = 0;
                1:       p = 63;
                2:       p = $urandom_range(13, 40);
                default: p = $urandom_range(1, 12);
            endcase
            n    = (p >= 40) ? $urandom_range(1, 3) : $urandom_range(1, 10);
            qmax = ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(0, 3);
            build_set(n, p, 0, qmax);
            case ($urandom_range(0, 5))
                0, 1:    target = coded_values[$urandom_range(0, n - 1)];
                2:       target = coded_values[$urandom_range(0, n - 1)] + 64'd1;
                3:       target = 64'hFFFF_FFFF_FFFF_FFFF;
                4:       target = {$urandom, $urandom};
                default: target = 64'd0;
            endcase
            case ($urandom_range(0, 4))
                0, 1:    size = 32'(n);
                2:       size = $urandom_range(0, n);
                3:       size = 32'(n + $urandom_range(1, 3));
                default: size = 32'hFFFF_FFFF;
            endcase
            shape = $urandom_range(0, 99);
            if (shape >= 70 && shape < 80 && stream_bytes.size() > 1)
            begin
                // truncated: stream ends early, possibly mid code
                cut = $urandom_range(1, stream_bytes.size() - 1);
                while (stream_bytes.size() > cut)
                    void'(stream_bytes.pop_back());
                stream_bytes[cut - 1].last_byte = 1'b1;
            end
            else if (shape >= 80 && shape < 88)
            begin
                stream_bytes[stream_bytes.size() - 1].last_byte = 1'b0;
            end
            else if (shape >= 88)
            begin
                stream_bytes.delete();
                repeat ($urandom_range(1, 6))
                begin
                    it = gcs_in_t'(10'($urandom));
                    stream_bytes.push_back(it);
                end
            end
            settle();
            configure(6'(p), size, target);
            run_stream(set_no % 16 == 3);
            set_no++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern, checker, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (pop_left == 0)
            begin
                pop_mode = $urandom_range(0, 3);
                pop_left = $urandom_range(1, 40);
            end
            pop_left--;
            case (pop_mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                2:       pop <= 1'b0;
                default: pop <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Values read here are those from just before the edge.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected verdict transaction: found %0d cause %0d elements %0d",
                       out_item.found, out_item.verdict_cause, out_item.elements_decoded);
                fail_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                checked++;
                cause_seen[want.verdict_cause]++;
                if (want.found)
                    found_seen++;
                if (out_item.found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, out_item.found);
                    fail_count++;
                end
                if (out_item.verdict_cause !== want.verdict_cause)
                begin
                    $error("verdict_cause: expected %0d, actual %0d",
                           want.verdict_cause, out_item.verdict_cause);
                    fail_count++;
                end
                if (out_item.elements_decoded !== want.elements_decoded)
                begin
                    $error("elements_decoded: expected %0d, actual %0d",
                           want.elements_decoded, out_item.elements_decoded);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no transaction for %0d cycles, %0d verdicts outstanding",
               WATCHDOG_LIMIT, pending_verdicts.size());
        $display("FAIL gcs_single_member_match");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        cur_rice   = GCS_RICE_RESET;
        cur_size   = '0;
        cur_target = '0;
        clear_query();
        foreach (cause_seen[i])
            cause_seen[i] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_empty_set();
        test_rice_zero();
        test_verdict_causes();
        test_after_verdict();
        test_wide_rice();
        test_random_sets();

        settle();
        $display("Sent %0d byte transactions (%0d decoded, rest dropped after a verdict), "
                 , sent_items, live_items);
        $display("checked %0d verdicts: %0d found, causes equal/passed/exhausted/end %0d/%0d/%0d/%0d",
                 checked, found_seen,
                 cause_seen[0], cause_seen[1], cause_seen[2], cause_seen[3]);
        if (fail_count == 0)
            $display("PASS gcs_single_member_match");
        else
            $display("FAIL gcs_single_member_match");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/gcs_pkg.sv
hw/rtl/gcs_queue.sv
hw/rtl/gcs_front.sv
hw/rtl/gcs_back.sv
hw/rtl/gcs_single_member_match.sv
sim/gcs_single_member_match_tb.sv
